### hw/rtl/rltq_pkg.sv
`timescale 1ns / 1ps

package rltq_pkg;

   localparam int LOG_DEPTH   = 64;
   localparam int PTR_W       = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W       = $clog2(LOG_DEPTH + 1);
   localparam int NUM_W       = 7;
   localparam int MAX_RESULTS = 64;
   localparam int TIME_W      = 32;
   localparam int TEMP_W      = 16;
   localparam int OP_W        = 2;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic        [TIME_W-1:0] stamp;
      logic signed [TEMP_W-1:0] temp;
   } record_type;

   typedef struct packed {
      logic [PTR_W-1:0] wp;
      logic [CNT_W-1:0] count;
   } status_type;

   // slot after p, wrapping at the log depth
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W:0] sum;
      sum = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
      if (sum == (PTR_W+1)'(LOG_DEPTH)) begin
         return '0;
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

### hw/rtl/ring_log_time_window_query_top.sv
`timescale 1ns / 1ps

// channel   ports                          transfer
// -------   -----------------------------  ----------------------------------
// request   start, busy, req_*             edge with start high and busy low
// result    rsp_strobe, rsp_*              every edge with rsp_strobe high
//
// append and clear are done from the idle state; busy stays low after them.
// a query holds busy while the log is walked: one record is read
// from the log memory and checked against the window by one compare unit per
// cycle, then a flush state closes the run. reaching the limit ends the walk early.
// the last result shows in the first cycle after busy drops. results may come
// on consecutive cycles or with gaps where records miss the window.
// synchronous reset empties the log; the receiver cannot stall, so each
// result is shown for exactly one cycle.

module ring_log_time_window_query_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rltq_pkg::OP_W-1:0]         req_operation,
   input  logic [rltq_pkg::TIME_W-1:0]       req_record_time,
   input  logic signed [rltq_pkg::TEMP_W-1:0] req_record_temperature,
   input  logic [rltq_pkg::TIME_W-1:0]       req_window_start,
   input  logic [rltq_pkg::TIME_W-1:0]       req_window_end,
   input  logic [rltq_pkg::NUM_W-1:0]        req_result_limit,
   output logic                              rsp_strobe,
   output logic                              rsp_has_record,
   output logic [rltq_pkg::TIME_W-1:0]       rsp_found_time,
   output logic signed [rltq_pkg::TEMP_W-1:0] rsp_found_temperature,
   output logic [rltq_pkg::NUM_W-1:0]        rsp_match_number,
   output logic                              rsp_last_of_run
);

   localparam int SUM_W = rltq_pkg::CNT_W + 1;

   rltq_pkg::state_type              state_ff, state_in;
   logic [rltq_pkg::TIME_W-1:0]      ws_ff, ws_in;
   logic [rltq_pkg::TIME_W-1:0]      we_ff, we_in;
   logic [rltq_pkg::NUM_W-1:0]       limit_ff, limit_in;
   logic [rltq_pkg::NUM_W-1:0]       n_ff, n_in;
   logic [rltq_pkg::PTR_W-1:0]       idx_ff, idx_in;
   logic [rltq_pkg::CNT_W-1:0]       left_ff, left_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic                             pend_vld_ff, pend_vld_in;
   rltq_pkg::record_type             pend_ff, pend_in;

   logic                             rsp_strobe_ff, rsp_strobe_in;
   logic                             rsp_has_ff, rsp_has_in;
   rltq_pkg::record_type             rsp_rec_ff, rsp_rec_in;
   logic [rltq_pkg::NUM_W-1:0]       rsp_num_ff, rsp_num_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             wr_en, clr, rd_en;
   rltq_pkg::record_type             wr_rec, rd_rec;
   rltq_pkg::status_type             status;
   logic                             in_window, hit;
   logic [rltq_pkg::NUM_W-1:0]       n_next;
   logic [SUM_W-1:0]                 wp_ext, cnt_ext, start_sum;

   assign wr_rec.stamp = req_record_time;
   assign wr_rec.temp  = req_record_temperature;

   rltq_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_rec  (wr_rec),
      .clr     (clr),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_rec  (rd_rec),
      .status  (status)
   );

   // oldest slot: write pointer minus count, wrapped
   assign wp_ext  = SUM_W'(status.wp);
   assign cnt_ext = SUM_W'(status.count);
   assign start_sum = (wp_ext >= cnt_ext) ? (wp_ext - cnt_ext)
                    : (wp_ext + SUM_W'(rltq_pkg::LOG_DEPTH) - cnt_ext);

   assign in_window = (rd_rec.stamp >= ws_ff) && (rd_rec.stamp <= we_ff);
   assign hit       = rd_vld_ff && in_window && (n_ff < limit_ff);
   assign n_next    = hit ? n_ff + 1'b1 : n_ff;

   always_comb begin
      state_in      = state_ff;
      ws_in         = ws_ff;
      we_in         = we_ff;
      limit_in      = limit_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      rd_vld_in     = 1'b0;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_has_in    = rsp_has_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      clr           = 1'b0;
      rd_en         = 1'b0;

      case (state_ff)
         rltq_pkg::ST_IDLE: begin
            if (start) begin
               case (req_operation)
                  rltq_pkg::OP_APPEND: begin
                     wr_en = 1'b1;
                  end
                  rltq_pkg::OP_CLEAR: begin
                     clr = 1'b1;
                  end
                  rltq_pkg::OP_QUERY: begin
                     ws_in       = req_window_start;
                     we_in       = req_window_end;
                     limit_in    = (req_result_limit > rltq_pkg::NUM_W'(rltq_pkg::MAX_RESULTS))
                                 ? rltq_pkg::NUM_W'(rltq_pkg::MAX_RESULTS) : req_result_limit;
                     idx_in      = start_sum[rltq_pkg::PTR_W-1:0];
                     left_in     = status.count;
                     n_in        = '0;
                     pend_vld_in = 1'b0;
                     state_in    = rltq_pkg::ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         rltq_pkg::ST_WALK: begin
            // read of one slot overlaps the check of the one before it
            rd_en     = (left_ff != '0);
            rd_vld_in = rd_en;
            if (rd_en) begin
               idx_in  = rltq_pkg::ptr_next(idx_ff);
               left_in = left_ff - 1'b1;
            end
            // a match is held back until the next one so the final one can carry last
            if (hit) begin
               pend_vld_in = 1'b1;
               pend_in     = rd_rec;
               n_in        = n_next;
               if (pend_vld_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_has_in    = 1'b1;
                  rsp_rec_in    = pend_ff;
                  rsp_num_in    = n_ff;
                  rsp_last_in   = 1'b0;
               end
            end
            if ((n_next == limit_ff) || (left_ff == '0)) begin
               state_in = rltq_pkg::ST_FLUSH;
            end
         end

         rltq_pkg::ST_FLUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            if (pend_vld_ff) begin
               rsp_has_in = 1'b1;
               rsp_rec_in = pend_ff;
               rsp_num_in = n_ff;
            end else begin
               rsp_has_in = 1'b0;
               rsp_rec_in = '0;
               rsp_num_in = '0;
            end
            state_in = rltq_pkg::ST_IDLE;
         end

         default: begin
            state_in = rltq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rltq_pkg::ST_IDLE;
         rd_vld_ff     <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ws_ff       <= ws_in;
      we_ff       <= we_in;
      limit_ff    <= limit_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      left_ff     <= left_in;
      pend_ff     <= pend_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy                  = (state_ff != rltq_pkg::ST_IDLE);
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_has_record        = rsp_has_ff;
   assign rsp_found_time        = rsp_rec_ff.stamp;
   assign rsp_found_temperature = rsp_rec_ff.temp;
   assign rsp_match_number      = rsp_num_ff;
   assign rsp_last_of_run       = rsp_last_ff;

endmodule

### hw/rtl/rltq_store.sv
`timescale 1ns / 1ps

module rltq_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  rltq_pkg::record_type         wr_rec,
   input  logic                         clr,
   input  logic                         rd_en,
   input  logic [rltq_pkg::PTR_W-1:0]   rd_addr,
   output rltq_pkg::record_type         rd_rec,
   output rltq_pkg::status_type         status
);

   rltq_pkg::record_type               mem [rltq_pkg::LOG_DEPTH];
   rltq_pkg::record_type               rd_rec_ff;
   logic [rltq_pkg::PTR_W-1:0]         wp_ff;
   logic [rltq_pkg::PTR_W-1:0]         wp_in;
   logic [rltq_pkg::CNT_W-1:0]         count_ff;
   logic [rltq_pkg::CNT_W-1:0]         count_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= wr_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      wp_in    = wp_ff;
      count_in = count_ff;
      if (clr) begin
         wp_in    = '0;
         count_in = '0;
      end else if (wr_en) begin
         wp_in = rltq_pkg::ptr_next(wp_ff);
         // once full the oldest record is overwritten and the count holds
         if (count_ff != rltq_pkg::CNT_W'(rltq_pkg::LOG_DEPTH)) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         count_ff <= count_in;
      end
   end

   assign rd_rec       = rd_rec_ff;
   assign status.wp    = wp_ff;
   assign status.count = count_ff;

endmodule
